[design/srarq_pkg.sv]
package srarq_pkg;

  localparam int SEQ_BITS    = 6;
  localparam int WINDOW      = 32;
  localparam int MAX_PAYLOAD = 256;
  localparam int SLOT_W      = $clog2(WINDOW);
  localparam int LEN_W       = 9;
  localparam int CNT_W       = $clog2(WINDOW) + 1;
  localparam int REL_W       = SEQ_BITS + 1;

  localparam logic [2:0] CMD_NEW   = 3'd0;
  localparam logic [2:0] CMD_READY = 3'd1;
  localparam logic [2:0] CMD_FRAME = 3'd2;
  localparam logic [2:0] CMD_DTO   = 3'd3;
  localparam logic [2:0] CMD_ATO   = 3'd4;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_NAK  = 2'd2;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_DATA    = 3'd1;
  localparam logic [2:0] ACT_ACK     = 3'd2;
  localparam logic [2:0] ACT_NAK     = 3'd3;
  localparam logic [2:0] ACT_STORE   = 3'd4;
  localparam logic [2:0] ACT_DELIVER = 3'd5;
  localparam logic [2:0] ACT_RELEASE = 3'd6;

  localparam logic [LEN_W-1:0] CTRL_LEN  = LEN_W'(3);
  localparam logic [LEN_W-1:0] CRC_LEN   = LEN_W'(5);
  localparam logic [LEN_W-1:0] OVERHEAD  = LEN_W'(7);
  localparam logic [LEN_W-1:0] MAX_PLEN  = LEN_W'(MAX_PAYLOAD);

  typedef struct packed {
    logic latch;
    logic eval;
    logic emit_store;
    logic emit_single;
    logic emit_dlv;
    logic emit_rel;
    logic last;
  } ctl_t;

  typedef struct packed {
    logic store;
    logic release_go;
    logic dlv_first;
    logic mark_next;
  } stat_t;

  function automatic logic in_window(input logic [SEQ_BITS-1:0] a,
                                     input logic [SEQ_BITS-1:0] b,
                                     input logic [SEQ_BITS-1:0] c);
    return (a <= b && b < c) || (c < a && a <= b) || (b < c && c < a);
  endfunction

endpackage

[design/srarq_ram.sv]
module srarq_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

[design/srarq_ctrl.sv]
module srarq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  srarq_pkg::stat_t    st,
  output srarq_pkg::ctl_t     ctl,
  output logic                busy
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_EVAL    = 5'b00010,
    S_DLV_RD  = 5'b00100,
    S_DLV_OUT = 5'b01000,
    S_REL     = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.latch = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        ctl.eval = 1'b1;
        if (st.store) begin
          ctl.emit_store = 1'b1;
          ctl.last       = !st.dlv_first && !st.release_go;
          if (st.dlv_first) state_nxt = S_DLV_RD;
          else if (st.release_go) state_nxt = S_REL;
          else state_nxt = S_IDLE;
        end else if (st.release_go) begin
          ctl.emit_rel = 1'b1;
          ctl.last     = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          ctl.emit_single = 1'b1;
          ctl.last        = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_DLV_RD: begin
        state_nxt = S_DLV_OUT;
      end
      S_DLV_OUT: begin
        ctl.emit_dlv = 1'b1;
        ctl.last     = !st.mark_next && !st.release_go;
        if (st.mark_next) state_nxt = S_DLV_RD;
        else if (st.release_go) state_nxt = S_REL;
        else state_nxt = S_IDLE;
      end
      S_REL: begin
        ctl.emit_rel = 1'b1;
        ctl.last     = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

endmodule

[design/srarq_dp.sv]
module srarq_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  srarq_pkg::ctl_t                   ctl,
  output srarq_pkg::stat_t                  st,
  input  logic [2:0]                        in_command,
  input  logic [srarq_pkg::LEN_W-1:0]       in_rx_length,
  input  logic                              in_rx_crc_ok,
  input  logic [1:0]                        in_rx_kind,
  input  logic [srarq_pkg::SEQ_BITS-1:0]    in_rx_seq,
  input  logic [srarq_pkg::SEQ_BITS-1:0]    in_rx_ack,
  input  logic [srarq_pkg::SLOT_W-1:0]      in_timer_slot,
  output logic                              out_valid,
  output logic [2:0]                        out_action,
  output logic [srarq_pkg::SEQ_BITS-1:0]    out_frame_seq,
  output logic [srarq_pkg::SEQ_BITS-1:0]    out_ack_no,
  output logic [srarq_pkg::SLOT_W-1:0]      out_slot,
  output logic [srarq_pkg::LEN_W-1:0]       out_payload_length,
  output logic                              out_restart_ack_timer,
  output logic                              out_network_enable,
  output logic                              out_last
);

  localparam int SB = srarq_pkg::SEQ_BITS;
  localparam int SW = srarq_pkg::SLOT_W;
  localparam int LW = srarq_pkg::LEN_W;
  localparam int CW = srarq_pkg::CNT_W;
  localparam int RW = srarq_pkg::REL_W;

  logic [2:0]    cmd_r;
  logic [LW-1:0] len_r;
  logic          crc_r;
  logic [1:0]    kind_r;
  logic [SB-1:0] rxseq_r, rxack_r;
  logic [SW-1:0] tslot_r;

  logic [SB-1:0] nts_r, old_r, exp_r, lim_r;
  logic [CW-1:0] outc_r;
  logic          phys_r, ne_r, restart_r;
  logic [srarq_pkg::WINDOW-1:0] marks_r;

  logic          ov_r, olast_r, ore_r, one_r;
  logic [2:0]    oact_r;
  logic [SB-1:0] oseq_r, oack_r;
  logic [SW-1:0] oslot_r;
  logic [LW-1:0] olen_r;

  logic          win_ack, short_f, bad_crc, frame_ok, is_data, send;
  logic [SW-1:0] rslot, exp_slot;
  logic [SB-1:0] ts0, tsel, exp_m1;
  logic          t_ok;
  logic [2:0]    s_act;
  logic [SB-1:0] s_seq, s_ack;
  logic [RW-1:0] rel_n;
  logic [CW-1:0] outc_rel, outc_fin;
  logic          phys_fin, ne_fin;
  logic [LW-1:0] plen, len_m7;
  logic [LW-1:0] ram_rdata;

  assign rslot    = rxseq_r[SW-1:0];
  assign exp_slot = exp_r[SW-1:0];
  assign exp_m1   = SB'(exp_r - SB'(1));
  assign win_ack  = srarq_pkg::in_window(old_r, rxack_r, nts_r);
  assign short_f  = (len_r < srarq_pkg::CRC_LEN) && (len_r != srarq_pkg::CTRL_LEN);
  assign bad_crc  = (len_r >= srarq_pkg::CRC_LEN) && !crc_r;
  assign frame_ok = (cmd_r == srarq_pkg::CMD_FRAME) && !short_f && !bad_crc;
  assign is_data  = frame_ok && (kind_r == srarq_pkg::KIND_DATA);
  assign ts0      = SB'(tslot_r);
  assign tsel     = srarq_pkg::in_window(old_r, ts0, nts_r) ? ts0
                  : SB'(ts0 + SB'(srarq_pkg::WINDOW));
  assign t_ok     = srarq_pkg::in_window(old_r, tsel, nts_r);

  assign st.store      = is_data && srarq_pkg::in_window(exp_r, rxseq_r, lim_r)
                         && !marks_r[rslot];
  assign st.release_go = frame_ok && (kind_r != srarq_pkg::KIND_NAK) && win_ack;
  assign st.dlv_first  = (rslot == exp_slot);
  assign st.mark_next  = marks_r[SW'(exp_slot + SW'(1))];

  always_comb begin
    send  = 1'b0;
    s_act = srarq_pkg::ACT_NONE;
    s_seq = '0;
    s_ack = '0;
    case (cmd_r)
      srarq_pkg::CMD_NEW: begin
        if (outc_r < CW'(srarq_pkg::WINDOW)) begin
          send  = 1'b1;
          s_seq = nts_r;
        end
      end
      srarq_pkg::CMD_FRAME: begin
        if (short_f) begin
          s_act = srarq_pkg::ACT_NONE;
        end else if (bad_crc) begin
          s_act = srarq_pkg::ACT_NAK;
          s_ack = exp_r;
        end else if (kind_r == srarq_pkg::KIND_NAK && win_ack) begin
          send  = 1'b1;
          s_seq = rxack_r;
        end
      end
      srarq_pkg::CMD_DTO: begin
        if (t_ok) begin
          send  = 1'b1;
          s_seq = tsel;
        end
      end
      srarq_pkg::CMD_ATO: begin
        s_act = srarq_pkg::ACT_ACK;
        s_ack = exp_m1;
      end
      default: s_act = srarq_pkg::ACT_NONE;
    endcase
    if (send) begin
      s_act = srarq_pkg::ACT_DATA;
      s_ack = exp_m1;
    end
  end

  assign rel_n    = RW'({1'b0, SB'(rxack_r - old_r)} + RW'(1));
  assign outc_rel = (RW'(outc_r) > rel_n) ? CW'(RW'(outc_r) - rel_n) : '0;
  assign outc_fin = st.release_go ? outc_rel
                  : (cmd_r == srarq_pkg::CMD_NEW && send) ? CW'(outc_r + CW'(1)) : outc_r;
  assign phys_fin = send ? 1'b0 : (cmd_r == srarq_pkg::CMD_READY) ? 1'b1 : phys_r;
  assign ne_fin   = (outc_fin < CW'(srarq_pkg::WINDOW)) && phys_fin;

  assign len_m7 = LW'(len_r - srarq_pkg::OVERHEAD);
  assign plen   = (len_r < srarq_pkg::OVERHEAD) ? '0
                : (len_m7 > srarq_pkg::MAX_PLEN) ? srarq_pkg::MAX_PLEN : len_m7;

  srarq_ram #(.WIDTH(LW), .DEPTH(srarq_pkg::WINDOW)) u_len_ram (
    .clk   (clk),
    .we    (ctl.emit_store),
    .addr  (ctl.emit_store ? rslot : exp_slot),
    .wdata (plen),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r   <= in_command;
      len_r   <= in_rx_length;
      crc_r   <= in_rx_crc_ok;
      kind_r  <= in_rx_kind;
      rxseq_r <= in_rx_seq;
      rxack_r <= in_rx_ack;
      tslot_r <= in_timer_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nts_r     <= '0;
      old_r     <= '0;
      exp_r     <= '0;
      lim_r     <= SB'(srarq_pkg::WINDOW);
      outc_r    <= '0;
      phys_r    <= 1'b0;
      ne_r      <= 1'b0;
      restart_r <= 1'b0;
      marks_r   <= '0;
      ov_r      <= 1'b0;
    end else begin
      ov_r <= ctl.emit_store | ctl.emit_single | ctl.emit_dlv | ctl.emit_rel;
      if (ctl.eval) begin
        ne_r      <= ne_fin;
        restart_r <= is_data;
      end
      if (ctl.emit_single) begin
        phys_r <= phys_fin;
        if (cmd_r == srarq_pkg::CMD_NEW && send) begin
          outc_r <= outc_fin;
          nts_r  <= SB'(nts_r + SB'(1));
        end
      end
      if (ctl.emit_store) begin
        marks_r[rslot] <= 1'b1;
      end
      if (ctl.emit_dlv) begin
        marks_r[exp_slot] <= 1'b0;
        exp_r <= SB'(exp_r + SB'(1));
        lim_r <= SB'(lim_r + SB'(1));
      end
      if (ctl.emit_rel) begin
        outc_r <= outc_rel;
        old_r  <= SB'(rxack_r + SB'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    olast_r <= ctl.last;
    ore_r   <= ctl.eval ? is_data : restart_r;
    one_r   <= ctl.eval ? ne_fin : ne_r;
    oact_r  <= srarq_pkg::ACT_NONE;
    oseq_r  <= '0;
    oack_r  <= '0;
    oslot_r <= '0;
    olen_r  <= '0;
    if (ctl.emit_single) begin
      oact_r  <= s_act;
      oseq_r  <= s_seq;
      oack_r  <= s_ack;
      oslot_r <= send ? s_seq[SW-1:0] : '0;
    end else if (ctl.emit_store) begin
      oact_r  <= srarq_pkg::ACT_STORE;
      oslot_r <= rslot;
      olen_r  <= plen;
    end else if (ctl.emit_dlv) begin
      oact_r  <= srarq_pkg::ACT_DELIVER;
      oslot_r <= exp_slot;
      olen_r  <= ram_rdata;
    end else if (ctl.emit_rel) begin
      oact_r  <= srarq_pkg::ACT_RELEASE;
      oslot_r <= old_r[SW-1:0];
      olen_r  <= LW'(rel_n);
    end
  end

  assign out_valid             = ov_r;
  assign out_action            = oact_r;
  assign out_frame_seq         = oseq_r;
  assign out_ack_no            = oack_r;
  assign out_slot              = oslot_r;
  assign out_payload_length    = olen_r;
  assign out_restart_ack_timer = ore_r;
  assign out_network_enable    = one_r;
  assign out_last              = olast_r;

endmodule

[design/selective_repeat_arq_window_unit.sv]
// Selective-repeat ARQ window engine. Raise start with an event while busy is
// low; results then appear one per out_valid strobe and cannot be held off,
// the final one flagged by out_last. A simple event gives one result, registered
// from the evaluation state; a received data frame that completes a run gives a
// store result, then one deliver result after each slot length memory read,
// then possibly a release. busy drops on the cycle the final result is shown.
module selective_repeat_arq_window_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        in_command,
  input  logic [srarq_pkg::LEN_W-1:0]       in_rx_length,
  input  logic                              in_rx_crc_ok,
  input  logic [1:0]                        in_rx_kind,
  input  logic [srarq_pkg::SEQ_BITS-1:0]    in_rx_seq,
  input  logic [srarq_pkg::SEQ_BITS-1:0]    in_rx_ack,
  input  logic [srarq_pkg::SLOT_W-1:0]      in_timer_slot,
  output logic                              out_valid,
  output logic [2:0]                        out_action,
  output logic [srarq_pkg::SEQ_BITS-1:0]    out_frame_seq,
  output logic [srarq_pkg::SEQ_BITS-1:0]    out_ack_no,
  output logic [srarq_pkg::SLOT_W-1:0]      out_slot,
  output logic [srarq_pkg::LEN_W-1:0]       out_payload_length,
  output logic                              out_restart_ack_timer,
  output logic                              out_network_enable,
  output logic                              out_last
);

  srarq_pkg::ctl_t  ctl;
  srarq_pkg::stat_t st;

  srarq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .ctl   (ctl),
    .busy  (busy)
  );

  srarq_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .ctl                   (ctl),
    .st                    (st),
    .in_command            (in_command),
    .in_rx_length          (in_rx_length),
    .in_rx_crc_ok          (in_rx_crc_ok),
    .in_rx_kind            (in_rx_kind),
    .in_rx_seq             (in_rx_seq),
    .in_rx_ack             (in_rx_ack),
    .in_timer_slot         (in_timer_slot),
    .out_valid             (out_valid),
    .out_action            (out_action),
    .out_frame_seq         (out_frame_seq),
    .out_ack_no            (out_ack_no),
    .out_slot              (out_slot),
    .out_payload_length    (out_payload_length),
    .out_restart_ack_timer (out_restart_ack_timer),
    .out_network_enable    (out_network_enable),
    .out_last              (out_last)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted transaction did not raise busy");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid) else $error("result straight after last");

  a_none_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == srarq_pkg::ACT_NONE |-> out_last)
    else $error("empty result not final");
`endif

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [2:0] action;
    logic [5:0] frame_seq;
    logic [5:0] ack_no;
    logic [4:0] slot;
    logic [8:0] plen;
    logic       restart;
    logic       net_en;
    logic       last;
  } action_t;

  typedef struct packed {
    logic [2:0] command;
    logic [8:0] rx_length;
    logic       rx_crc_ok;
    logic [1:0] rx_kind;
    logic [5:0] rx_seq;
    logic [5:0] rx_ack;
    logic [4:0] timer_slot;
  } event_t;

  localparam int LIMIT = 2000000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [2:0] in_command;
  logic [8:0] in_rx_length;
  logic in_rx_crc_ok;
  logic [1:0] in_rx_kind;
  logic [5:0] in_rx_seq;
  logic [5:0] in_rx_ack;
  logic [4:0] in_timer_slot;
  logic out_valid;
  logic [2:0] out_action;
  logic [5:0] out_frame_seq;
  logic [5:0] out_ack_no;
  logic [4:0] out_slot;
  logic [8:0] out_payload_length;
  logic out_restart_ack_timer;
  logic out_network_enable;
  logic out_last;

  selective_repeat_arq_window_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_rx_length(in_rx_length), .in_rx_crc_ok(in_rx_crc_ok),
    .in_rx_kind(in_rx_kind), .in_rx_seq(in_rx_seq), .in_rx_ack(in_rx_ack),
    .in_timer_slot(in_timer_slot), .out_valid(out_valid), .out_action(out_action),
    .out_frame_seq(out_frame_seq), .out_ack_no(out_ack_no), .out_slot(out_slot),
    .out_payload_length(out_payload_length), .out_restart_ack_timer(out_restart_ack_timer),
    .out_network_enable(out_network_enable), .out_last(out_last)
  );

  // link state mirror
  logic [5:0] nxt_send, oldest, exp_seq, rcv_limit;
  int unsigned outstanding;
  logic phy_ready;
  logic arrived [srarq_pkg::WINDOW];
  logic [8:0] held_len [srarq_pkg::WINDOW];

  action_t expected_q[$];
  action_t step_q[$];
  int errors;
  int cycles;

  function automatic bit seq_in(input logic [5:0] a, input logic [5:0] b, input logic [5:0] c);
    return (a <= b && b < c) || (c < a && a <= b) || (b < c && c < a);
  endfunction

  function automatic void push_act(input logic [2:0] act, input logic [5:0] sq,
                                   input logic [5:0] ak, input logic [4:0] sl,
                                   input logic [8:0] ln);
    action_t r;
    r = '0;
    r.action = act; r.frame_seq = sq; r.ack_no = ak; r.slot = sl; r.plen = ln;
    step_q.push_back(r);
  endfunction

  function automatic void tx_data(input logic [5:0] sq);
    push_act(srarq_pkg::ACT_DATA, sq, exp_seq - 6'd1, sq[4:0], '0);
    phy_ready = 1'b0;
  endfunction

  function automatic void link_step(input event_t ev);
    logic restart;
    logic [5:0] s;
    logic [4:0] first;
    int n;
    int pl;
    restart = 1'b0;
    step_q.delete();
    case (ev.command)
      srarq_pkg::CMD_NEW: if (outstanding < srarq_pkg::WINDOW) begin
        outstanding++;
        tx_data(nxt_send);
        nxt_send = nxt_send + 6'd1;
      end
      srarq_pkg::CMD_READY: phy_ready = 1'b1;
      srarq_pkg::CMD_FRAME: begin
        if (ev.rx_length < srarq_pkg::CRC_LEN && ev.rx_length != srarq_pkg::CTRL_LEN) begin
        end else if (ev.rx_length >= srarq_pkg::CRC_LEN && !ev.rx_crc_ok) begin
          push_act(srarq_pkg::ACT_NAK, '0, exp_seq, '0, '0);
        end else if (ev.rx_kind == srarq_pkg::KIND_NAK) begin
          if (seq_in(oldest, ev.rx_ack, nxt_send)) tx_data(ev.rx_ack);
        end else begin
          if (ev.rx_kind == srarq_pkg::KIND_DATA) begin
            restart = 1'b1;
            if (seq_in(exp_seq, ev.rx_seq, rcv_limit) && !arrived[ev.rx_seq[4:0]]) begin
              pl = (ev.rx_length >= srarq_pkg::OVERHEAD) ? int'(ev.rx_length) - 7 : 0;
              if (pl > srarq_pkg::MAX_PAYLOAD) pl = srarq_pkg::MAX_PAYLOAD;
              arrived[ev.rx_seq[4:0]] = 1'b1;
              held_len[ev.rx_seq[4:0]] = pl[8:0];
              push_act(srarq_pkg::ACT_STORE, '0, '0, ev.rx_seq[4:0], pl[8:0]);
              while (arrived[exp_seq[4:0]]) begin
                push_act(srarq_pkg::ACT_DELIVER, '0, '0, exp_seq[4:0],
                         held_len[exp_seq[4:0]]);
                arrived[exp_seq[4:0]] = 1'b0;
                exp_seq = exp_seq + 6'd1;
                rcv_limit = rcv_limit + 6'd1;
              end
            end
          end
          if (seq_in(oldest, ev.rx_ack, nxt_send)) begin
            first = oldest[4:0];
            n = 0;
            while (seq_in(oldest, ev.rx_ack, nxt_send)) begin
              n++;
              if (outstanding > 0) outstanding--;
              oldest = oldest + 6'd1;
            end
            push_act(srarq_pkg::ACT_RELEASE, '0, '0, first, 9'(n));
          end
        end
      end
      srarq_pkg::CMD_DTO: begin
        s = {1'b0, ev.timer_slot};
        if (!seq_in(oldest, s, nxt_send)) s = s + 6'd32;
        if (seq_in(oldest, s, nxt_send)) tx_data(s);
      end
      srarq_pkg::CMD_ATO: push_act(srarq_pkg::ACT_ACK, '0, exp_seq - 6'd1, '0, '0);
      default: ;
    endcase
    if (step_q.size() == 0) push_act(srarq_pkg::ACT_NONE, '0, '0, '0, '0);
    foreach (step_q[k]) begin
      step_q[k].restart = restart;
      step_q[k].net_en = (outstanding < srarq_pkg::WINDOW) && phy_ready;
      step_q[k].last = (k == step_q.size() - 1);
      expected_q.push_back(step_q[k]);
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL selective_repeat_arq_window_unit");
      $finish;
    end
  end

  always @(posedge clk) begin
    action_t got, want;
    if (rst_n && out_valid) begin
      got = {out_action, out_frame_seq, out_ack_no, out_slot, out_payload_length,
             out_restart_ack_timer, out_network_enable, out_last};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected transaction %h", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic issue(input event_t ev);
    in_command <= ev.command; in_rx_length <= ev.rx_length; in_rx_crc_ok <= ev.rx_crc_ok;
    in_rx_kind <= ev.rx_kind; in_rx_seq <= ev.rx_seq; in_rx_ack <= ev.rx_ack;
    in_timer_slot <= ev.timer_slot;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    link_step(ev);
  endtask

  function automatic event_t mk(input int c, input int ln, input int ok, input int kd,
                                input int sq, input int ak, input int ts);
    return {3'(c), 9'(ln), 1'(ok), 2'(kd), 6'(sq), 6'(ak), 5'(ts)};
  endfunction

  function automatic event_t rand_event();
    event_t ev;
    int r;
    ev = $urandom;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      ev.command = 3'($urandom_range(5, 7));
      return ev;
    end
    if (r < 30) ev.command = srarq_pkg::CMD_NEW;
    else if (r < 42) ev.command = srarq_pkg::CMD_READY;
    else if (r < 85) ev.command = srarq_pkg::CMD_FRAME;
    else if (r < 93) ev.command = srarq_pkg::CMD_DTO;
    else ev.command = srarq_pkg::CMD_ATO;
    if (ev.command == srarq_pkg::CMD_FRAME && $urandom_range(0, 9) < 8) begin
      ev.rx_length = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511))
                                                   : 9'($urandom_range(5, 263));
      ev.rx_crc_ok = ($urandom_range(0, 9) != 0);
      ev.rx_kind = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(1, 3))
                                                 : srarq_pkg::KIND_DATA;
      ev.rx_seq = exp_seq + 6'($urandom_range(0, 35));
      ev.rx_ack = oldest + 6'($urandom_range(0, 40)) - 6'd1;
    end
    return ev;
  endfunction

  event_t plan[$];
  action_t plan_exp[$];
  bit plan_chk[$];

  function automatic void add_row(input event_t ev, input bit chk, input action_t ex);
    plan.push_back(ev);
    plan_chk.push_back(chk);
    plan_exp.push_back(ex);
  endfunction

  initial begin
    errors = 0; cycles = 0;
    nxt_send = '0; oldest = '0; exp_seq = '0; rcv_limit = 6'd32;
    outstanding = 0; phy_ready = 1'b0;
    foreach (arrived[i]) arrived[i] = 1'b0;
    rst_n = 1'b0; start = 1'b0;
    in_command = '0; in_rx_length = '0; in_rx_crc_ok = 1'b0; in_rx_kind = '0;
    in_rx_seq = '0; in_rx_ack = '0; in_timer_slot = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: ack timeout, bad crc, short frames, unknown cmds, full window, sat lengths
    add_row(mk(srarq_pkg::CMD_ATO, 0, 0, 0, 0, 0, 0), 1'b1,
            action_t'{srarq_pkg::ACT_ACK, 6'd0, 6'd63, 5'd0, 9'd0, 1'b0, 1'b0, 1'b1});
    add_row(mk(srarq_pkg::CMD_FRAME, 263, 0, srarq_pkg::KIND_DATA, 0, 0, 0), 1'b1,
            action_t'{srarq_pkg::ACT_NAK, 6'd0, 6'd0, 5'd0, 9'd0, 1'b0, 1'b0, 1'b1});
    add_row(mk(srarq_pkg::CMD_FRAME, 4, 1, srarq_pkg::KIND_DATA, 0, 0, 0), 1'b1,
            action_t'{srarq_pkg::ACT_NONE, 6'd0, 6'd0, 5'd0, 9'd0, 1'b0, 1'b0, 1'b1});
    add_row(mk(srarq_pkg::CMD_FRAME, 3, 0, srarq_pkg::KIND_DATA, 0, 63, 0), 1'b0, '0);
    add_row(mk(7, 511, 1, 3, 63, 63, 31), 1'b1,
            action_t'{srarq_pkg::ACT_NONE, 6'd0, 6'd0, 5'd0, 9'd0, 1'b0, 1'b0, 1'b1});
    add_row(mk(srarq_pkg::CMD_READY, 0, 0, 0, 0, 0, 0), 1'b1,
            action_t'{srarq_pkg::ACT_NONE, 6'd0, 6'd0, 5'd0, 9'd0, 1'b0, 1'b1, 1'b1});
    add_row(mk(srarq_pkg::CMD_NEW, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk(srarq_pkg::CMD_DTO, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk(srarq_pkg::CMD_DTO, 0, 0, 0, 0, 0, 31), 1'b0, '0);
    add_row(mk(srarq_pkg::CMD_FRAME, 5, 1, srarq_pkg::KIND_NAK, 0, 0, 0), 1'b0, '0);
    add_row(mk(srarq_pkg::CMD_FRAME, 5, 1, srarq_pkg::KIND_NAK, 0, 9, 0), 1'b0, '0);
    add_row(mk(srarq_pkg::CMD_FRAME, 511, 1, srarq_pkg::KIND_DATA, 2, 63, 0), 1'b0, '0);
    add_row(mk(srarq_pkg::CMD_FRAME, 6, 1, srarq_pkg::KIND_DATA, 1, 63, 0), 1'b0, '0);
    add_row(mk(srarq_pkg::CMD_FRAME, 7, 1, srarq_pkg::KIND_DATA, 0, 0, 0), 1'b0, '0);
    add_row(mk(srarq_pkg::CMD_FRAME, 40, 1, 3, 40, 63, 0), 1'b0, '0);
    add_row(mk(srarq_pkg::CMD_FRAME, 30, 1, srarq_pkg::KIND_DATA, 34, 5, 0), 1'b0, '0);
    for (int i = 0; i < 33; i++) add_row(mk(srarq_pkg::CMD_NEW, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk(srarq_pkg::CMD_DTO, 0, 0, 0, 0, 0, 1), 1'b0, '0);
    add_row(mk(srarq_pkg::CMD_FRAME, 3, 1, 1, 0, 32, 0), 1'b0, '0);
    foreach (plan[i]) begin
      idle_gap();
      issue(plan[i]);
      if (plan_chk[i] && step_q[0] !== plan_exp[i]) begin
        $display("%0t: row %0d expected %h actual %h", $time, i, plan_exp[i], step_q[0]);
        errors++;
      end
    end
    for (int i = 0; i < 280; i++) begin
      idle_gap();
      issue(rand_event());
    end
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("PASS selective_repeat_arq_window_unit");
    end else begin
      $display("FAIL selective_repeat_arq_window_unit");
    end
    $finish;
  end

endmodule

[selective_repeat_arq_window_unit.f]
design/srarq_pkg.sv
design/srarq_ram.sv
design/srarq_ctrl.sv
design/srarq_dp.sv
design/selective_repeat_arq_window_unit.sv
sim/tb_top.sv
